// ===== hdl/asrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared types, codes and helpers for the ADC sample ring capture block.
// ----------------------------------------------------------------------------
package asrc_pkg;

   localparam int MAX_READ  = 64;
   localparam int CNT_W     = 6;   // run length minus one
   localparam int PROD_W    = 16;  // (count - 1) * stride
   localparam int RED_STEPS = 3;   // modulo reduction cycles
   localparam int STEP_W    = 2;   // modulo reduction step counter

   localparam logic [15:0] BITS_MODE_RESET = 16'd2;
   localparam logic [31:0] VOLTS_RESET     = 32'd13504;

   typedef enum logic [1:0] {
      ACT_PUSH_RAW   = 2'd0,
      ACT_PUSH_VALUE = 2'd1,
      ACT_READ       = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MODE_8  = 2'd0,
      MODE_10 = 2'd1,
      MODE_12 = 2'd2,
      MODE_16 = 2'd3
   } bits_mode_type;

   typedef enum logic {
      REG_BITS_MODE = 1'b0,
      REG_VOLTS     = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ALIGN,
      ST_STREAM
   } state_type;

   typedef struct packed {
      logic [1:0]  bits_mode;
      logic [31:0] volts_per_code;
   } cfg_type;

   typedef struct packed {
      logic push_raw;
      logic push_value;
      logic load;
      logic reduce;
      logic align;
      logic issue;
      logic last;
   } dp_cmd_type;

   function automatic logic [6:0] sat_count(input logic [6:0] count);
      logic [6:0] result;
      result = (count > 7'(MAX_READ)) ? 7'(MAX_READ) : count;
      return result;
   endfunction

   function automatic logic [15:0] mode_mask(input logic [1:0] mode);
      logic [15:0] result;
      unique case (bits_mode_type'(mode))
         MODE_8:  result = 16'h00FF;
         MODE_10: result = 16'h03FF;
         MODE_12: result = 16'h0FFF;
         MODE_16: result = 16'hFFFF;
         default: result = 16'hFFFF;
      endcase
      return result;
   endfunction

   function automatic logic [15:0] mode_mid(input logic [1:0] mode);
      logic [15:0] result;
      unique case (bits_mode_type'(mode))
         MODE_8:  result = 16'd127;
         MODE_10: result = 16'd511;
         MODE_12: result = 16'd2047;
         MODE_16: result = 16'd32767;
         default: result = 16'd32767;
      endcase
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/asrc_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_csr
// Configuration registers: ADC width mode and volts per code.
// ----------------------------------------------------------------------------
module asrc_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output      logic [31:0]      prdata,
   output      logic             pready,
   output      asrc_pkg::cfg_type cfg
);
   import asrc_pkg::*;

   logic [1:0]    bits_mode_ff;
   logic [31:0]   volts_ff;
   logic          wr_en;
   reg_index_type index;

   assign index  = reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_mode_ff <= BITS_MODE_RESET[1:0];
         volts_ff     <= VOLTS_RESET;
      end else if (wr_en) begin
         unique case (index)
            REG_BITS_MODE: bits_mode_ff <= pwdata[1:0];
            REG_VOLTS:     volts_ff     <= pwdata;
            default:       volts_ff     <= volts_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_BITS_MODE: prdata = {30'd0, bits_mode_ff};
         REG_VOLTS:     prdata = volts_ff;
         default:       prdata = 32'd0;
      endcase
   end

   assign cfg.bits_mode      = bits_mode_ff;
   assign cfg.volts_per_code = volts_ff;

endmodule
`default_nettype wire

// ===== hdl/asrc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_ctrl
// Sequencer: dispatches pushes, runs the read setup and the read stream.
// ----------------------------------------------------------------------------
module asrc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_action,
   input  wire logic [6:0]           req_read_count,
   output      logic                 busy,
   output      asrc_pkg::dp_cmd_type cmd
);
   import asrc_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              accept;
   logic [6:0]        count_sat;
   action_type        action;

   assign action    = action_type'(req_action);
   assign count_sat = sat_count(req_read_count);
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && action == ACT_READ && count_sat != 7'd0) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (step_ff == STEP_W'(RED_STEPS - 1)) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: state_in = ST_STREAM;
         ST_STREAM: begin
            if (left_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd     = '0;
      step_in = step_ff;
      left_in = left_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               case (action)
                  ACT_PUSH_RAW:   cmd.push_raw   = 1'b1;
                  ACT_PUSH_VALUE: cmd.push_value = 1'b1;
                  ACT_READ: begin
                     cmd.load = (count_sat != 7'd0);
                     left_in  = CNT_W'(count_sat - 7'd1);
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            step_in    = step_ff + STEP_W'(1);
         end
         ST_ALIGN: cmd.align = 1'b1;
         ST_STREAM: begin
            cmd.issue = 1'b1;
            cmd.last  = (left_ff == '0);
            left_in   = left_ff - CNT_W'(1);
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         left_ff  <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/asrc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_datapath
// Sample conversion, ring memory, write pointer and read address walk.
// ----------------------------------------------------------------------------
module asrc_datapath #(
   parameter int DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire asrc_pkg::dp_cmd_type cmd,
   input  wire asrc_pkg::cfg_type    cfg,
   input  wire logic [15:0]          req_raw_sample,
   input  wire logic signed [31:0]   req_ready_value,
   input  wire logic [6:0]           req_read_count,
   input  wire logic [9:0]           req_read_stride,
   output      logic                 rsp_valid,
   output      logic signed [31:0]   rsp_sample_volts,
   output      logic                 rsp_last_of_read
);
   import asrc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = PTR_W + 1;
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / 64'(DEPTH));

   logic [31:0] mem [DEPTH];

   // push path
   logic [15:0]        masked;
   logic signed [16:0] diff;
   logic signed [32:0] vpc_s;
   logic signed [49:0] prod_in, prod_ff;
   logic signed [49:0] rounded;
   logic signed [31:0] value_ff;
   logic               pend_ff, is_value_ff;
   logic [31:0]        wr_word;
   logic [PTR_W-1:0]   wp_ff;
   logic               wrapped_ff;

   // read path
   logic [CNT_W-1:0]     cnt_m1;
   logic [PROD_W-1:0]    back_prod;
   logic [PROD_W-1:0]    x_ff, s_ff;
   logic [PROD_W+31:0]   qb_full, qs_full;
   logic [PROD_W-1:0]    qb_ff, qs_ff;
   logic [RW-1:0]        rb_ff, rs_ff;
   logic [PTR_W-1:0]     back_ff, stride_ff;
   logic [PTR_W-1:0]     newest;
   logic [PTR_W:0]       start_t, next_t;
   logic [PTR_W-1:0]     addr_ff;
   logic [31:0]          rd_ff;
   logic                 hit_ff, valid_ff, last_ff;

   assign masked  = req_raw_sample & mode_mask(cfg.bits_mode);
   assign diff    = $signed({1'b0, masked}) - $signed({1'b0, mode_mid(cfg.bits_mode)});
   assign vpc_s   = $signed({1'b0, cfg.volts_per_code});
   assign prod_in = diff * vpc_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.push_raw || cmd.push_value;
      end
      prod_ff     <= prod_in;
      value_ff    <= req_ready_value;
      is_value_ff <= cmd.push_value;
   end

   // round half up to q16.16, then saturate
   assign rounded = (prod_ff + 50'sd128) >>> 8;

   always_comb begin
      if (is_value_ff) begin
         wr_word = value_ff;
      end else if (rounded[49:31] == {19{rounded[49]}}) begin
         wr_word = rounded[31:0];
      end else if (rounded[49]) begin
         wr_word = 32'h8000_0000;
      end else begin
         wr_word = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else if (pend_ff) begin
         if (wp_ff == LAST_PTR) begin
            wp_ff      <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            wp_ff <= wp_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         mem[wp_ff] <= wr_word;
      end
   end

   // read setup: (count-1)*stride and stride modulo depth by reciprocal
   // multiply, back-multiply and one compare-subtract, each stage registered
   assign cnt_m1    = CNT_W'(sat_count(req_read_count) - 7'd1);
   assign back_prod = PROD_W'(cnt_m1) * PROD_W'(req_read_stride);

   assign qb_full = (PROD_W + 32)'(x_ff) * (PROD_W + 32)'(RECIP);
   assign qs_full = (PROD_W + 32)'(s_ff) * (PROD_W + 32)'(RECIP);

   assign newest  = (wp_ff == '0) ? LAST_PTR : wp_ff - PTR_W'(1);
   assign start_t = (newest >= back_ff)
                  ? ({1'b0, newest} - {1'b0, back_ff})
                  : ({1'b0, newest} - {1'b0, back_ff} + DEPTH_X);
   assign next_t  = {1'b0, addr_ff} + {1'b0, stride_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= back_prod;
         s_ff <= PROD_W'(req_read_stride);
      end
      if (cmd.reduce) begin
         qb_ff     <= qb_full[PROD_W+31:32];
         qs_ff     <= qs_full[PROD_W+31:32];
         rb_ff     <= RW'(x_ff) - RW'(qb_ff) * DEPTH_X;
         rs_ff     <= RW'(s_ff) - RW'(qs_ff) * DEPTH_X;
         back_ff   <= (rb_ff >= DEPTH_X) ? PTR_W'(rb_ff - DEPTH_X) : PTR_W'(rb_ff);
         stride_ff <= (rs_ff >= DEPTH_X) ? PTR_W'(rs_ff - DEPTH_X) : PTR_W'(rs_ff);
      end
      if (cmd.align) begin
         addr_ff <= PTR_W'(start_t);
      end else if (cmd.issue) begin
         addr_ff <= (next_t >= DEPTH_X) ? PTR_W'(next_t - DEPTH_X) : PTR_W'(next_t);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.issue;
      end
      hit_ff  <= wrapped_ff || (addr_ff < wp_ff);
      last_ff <= cmd.last;
   end

   // entries not yet written since reset read as zero
   assign rsp_valid        = valid_ff;
   assign rsp_sample_volts = hit_ff ? $signed(rd_ff) : 32'sd0;
   assign rsp_last_of_read = valid_ff && last_ff;

endmodule
`default_nettype wire

// ===== hdl/adc_sample_ring_capture.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sample_ring_capture
// Oscilloscope capture ring with raw ADC conversion to Q16.16 volts.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A push of a raw
// word or of a ready value does not raise busy, so pushes stream at one
// per cycle while no read is running; the product is registered at accept
// and the rounded sample is written into the ring from that register.
// A read raises busy, reduces (count-1)*stride and the stride modulo
// DEPTH (reciprocal multiply, back-multiply, compare and subtract),
// aligns the start address, then issues one memory read per cycle.
// Results appear on rsp_valid in the cycle after each issue, oldest
// first, with last_of_read on the newest sample. A read of count zero
// does not raise busy and returns nothing.
// Each result is shown for one cycle only; the receiver cannot stall it.
// Reset clears the write pointer and a wrap flag; positions not yet written
// since reset read back as zero, so no clearing pass is needed.
// Registers: 0 = sample width mode at byte 0, 1 = volts per code at byte 4.
// ----------------------------------------------------------------------------
module adc_sample_ring_capture #(
   parameter int DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [1:0]         req_action,
   input  wire logic [15:0]        req_raw_sample,
   input  wire logic signed [31:0] req_ready_value,
   input  wire logic [6:0]         req_read_count,
   input  wire logic [9:0]         req_read_stride,
   output      logic               rsp_valid,
   output      logic signed [31:0] rsp_sample_volts,
   output      logic               rsp_last_of_read,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output      logic [31:0]        prdata,
   output      logic               pready
);
   import asrc_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;

   asrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   asrc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_action     (req_action),
      .req_read_count (req_read_count),
      .busy           (busy),
      .cmd            (cmd)
   );

   asrc_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_raw_sample   (req_raw_sample),
      .req_ready_value  (req_ready_value),
      .req_read_count   (req_read_count),
      .req_read_stride  (req_read_stride),
      .rsp_valid        (rsp_valid),
      .rsp_sample_volts (rsp_sample_volts),
      .rsp_last_of_read (rsp_last_of_read)
   );

   // results only come out of a running read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a running read");

   // a push never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action != ACT_READ) |=> !rsp_valid)
      else $error("push produced a result");

   // nothing follows the final item of a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_read) |=> !rsp_valid)
      else $error("result after end of run");

   // the read stays busy until its final item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_read) |-> busy)
      else $error("read ended before its final item");

endmodule
`default_nettype wire
